// ----- src/qbez_pkg.sv -----
package qbez_pkg;

   // field and register widths
   localparam int PARAM_W     = 17;
   localparam int POINT_W     = 32;
   localparam int POS_W       = 32;
   localparam int SLOPE_W     = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_POINTS  = 6;
   localparam int NUM_DIFFS   = NUM_POINTS - 1;

   // t = 1 in Q1.16
   localparam logic [PARAM_W-1:0] ONE_Q16 = 17'd65536;

   // monomial widths: squares hold 2^32, degree four 2^64, degree five 2^80
   localparam int SQ_W    = 33;
   localparam int MONO4_W = 65;
   localparam int MONO5_W = 81;

   // scaled control points and scaled differences
   localparam int COEF_W = 36;
   localparam int DIFF_W = 38;

   // partial product split of the monomials
   localparam int NUM_CHUNKS  = 3;
   localparam int POS_CHUNK_W = 27;
   localparam int SLP_CHUNK_W = 22;
   localparam int POS_PP_W    = POS_CHUNK_W + 1 + COEF_W;
   localparam int SLP_PP_W    = SLP_CHUNK_W + 1 + DIFF_W;

   // accumulator widths and binary point positions
   localparam int POS_ACC_W = 119;
   localparam int SLP_ACC_W = 105;
   localparam int POS_FRAC  = 80;
   localparam int SLP_FRAC  = 64;

   localparam logic signed [POS_ACC_W-1:0] POS_HALF = POS_ACC_W'(1) << (POS_FRAC - 1);
   localparam logic signed [SLP_ACC_W-1:0] SLP_HALF = SLP_ACC_W'(1) << (SLP_FRAC - 1);

   // pipeline depth, output register included
   localparam int NUM_STAGES = 9;

   // binomial weights for the curve value, and 5*C(4,k) for the derivative
   localparam logic [3:0] POS_BINOM [NUM_POINTS] = '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1};
   localparam logic [4:0] SLP_WEIGHT [NUM_DIFFS] = '{5'd5, 5'd20, 5'd30, 5'd20, 5'd5};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POINT_ZERO  = 3'd0,
      REG_POINT_ONE   = 3'd1,
      REG_POINT_TWO   = 3'd2,
      REG_POINT_THREE = 3'd3,
      REG_POINT_FOUR  = 3'd4,
      REG_POINT_FIVE  = 3'd5
   } csr_reg_type;

   typedef logic        [PARAM_W-1:0]    param_type;
   typedef logic signed [POINT_W-1:0]    point_type;
   typedef logic        [SQ_W-1:0]       square_type;
   typedef logic        [MONO4_W-1:0]    mono4_type;
   typedef logic        [MONO5_W-1:0]    mono5_type;
   typedef logic signed [COEF_W-1:0]     coef_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [POS_ACC_W-1:0]  pos_acc_type;
   typedef logic signed [SLP_ACC_W-1:0]  slp_acc_type;
   typedef logic        [NUM_STAGES-1:0] stage_en_type;

endpackage

// ----- src/qbez_csr.sv -----
module qbez_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qbez_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qbez_pkg::POINT_W-1:0]        csr_data,
   output qbez_pkg::coef_type                  coef [qbez_pkg::NUM_POINTS],
   output qbez_pkg::diff_type                  diff [qbez_pkg::NUM_DIFFS]
);

   qbez_pkg::point_type point_ff [qbez_pkg::NUM_POINTS];
   qbez_pkg::point_type point_in [qbez_pkg::NUM_POINTS];
   qbez_pkg::coef_type  coef_ff  [qbez_pkg::NUM_POINTS];
   qbez_pkg::coef_type  coef_in  [qbez_pkg::NUM_POINTS];
   qbez_pkg::diff_type  diff_ff  [qbez_pkg::NUM_DIFFS];
   qbez_pkg::diff_type  diff_in  [qbez_pkg::NUM_DIFFS];
   logic signed [qbez_pkg::POINT_W:0] delta [qbez_pkg::NUM_DIFFS];

   assign csr_ready = 1'b1;

   // register write decode, unknown indexes are dropped
   always_comb begin
      for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
         point_in[k] = point_ff[k];
      end
      if (csr_valid) begin
         case (csr_index)
            qbez_pkg::REG_POINT_ZERO:  point_in[0] = csr_data;
            qbez_pkg::REG_POINT_ONE:   point_in[1] = csr_data;
            qbez_pkg::REG_POINT_TWO:   point_in[2] = csr_data;
            qbez_pkg::REG_POINT_THREE: point_in[3] = csr_data;
            qbez_pkg::REG_POINT_FOUR:  point_in[4] = csr_data;
            qbez_pkg::REG_POINT_FIVE:  point_in[5] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
            point_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
            point_ff[k] <= point_in[k];
         end
      end
   end

   // points scaled by their binomial weight, differences by 5*C(4,k)
   always_comb begin
      for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
         coef_in[k] = point_ff[k] * $signed({1'b0, qbez_pkg::POS_BINOM[k]});
      end
      for (int k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
         delta[k]   = point_ff[k+1] - point_ff[k];
         diff_in[k] = delta[k] * $signed({1'b0, qbez_pkg::SLP_WEIGHT[k]});
      end
   end

   // registered from the stored points, ready well before a request reaches the products
   always_ff @(posedge clock) begin
      for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
         coef_ff[k] <= coef_in[k];
      end
      for (int k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
         diff_ff[k] <= diff_in[k];
      end
   end

   assign coef = coef_ff;
   assign diff = diff_ff;

endmodule

// ----- src/qbez_basis.sv -----
module qbez_basis (
   input  logic                   clock,
   input  qbez_pkg::stage_en_type en,
   input  qbez_pkg::param_type    curve_param,
   output qbez_pkg::mono4_type    mono4 [qbez_pkg::NUM_DIFFS],
   output qbez_pkg::mono5_type    mono5 [qbez_pkg::NUM_POINTS]
);

   localparam int SQ_FULL_W = 2 * qbez_pkg::PARAM_W;
   localparam int M4_FULL_W = 2 * qbez_pkg::SQ_W;
   localparam int M5_FULL_W = qbez_pkg::MONO4_W + qbez_pkg::PARAM_W;

   // stage one: clamped t and u = 1 - t
   qbez_pkg::param_type t_ff, t_in, u_ff, u_in;
   // stage two: squares and cross term
   qbez_pkg::square_type t2_ff, u2_ff, tu_ff;
   qbez_pkg::param_type  t_s2_ff, u_s2_ff;
   logic [SQ_FULL_W-1:0] t2_full, u2_full, tu_full;
   // stage three: degree four monomials, index is the power of t
   qbez_pkg::mono4_type  m4_ff [qbez_pkg::NUM_DIFFS];
   logic [M4_FULL_W-1:0] m4_full [qbez_pkg::NUM_DIFFS];
   qbez_pkg::param_type  t_s3_ff, u_s3_ff;
   // stage four: degree five monomials
   qbez_pkg::mono5_type  m5_ff [qbez_pkg::NUM_POINTS];
   logic [M5_FULL_W-1:0] m5_full [qbez_pkg::NUM_POINTS];
   qbez_pkg::mono4_type  m4_s4_ff [qbez_pkg::NUM_DIFFS];

   // parameter beyond one is taken as one
   always_comb begin
      t_in = (curve_param > qbez_pkg::ONE_Q16) ? qbez_pkg::ONE_Q16 : curve_param;
      u_in = qbez_pkg::ONE_Q16 - t_in;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff <= t_in;
         u_ff <= u_in;
      end
   end

   // squares
   always_comb begin
      t2_full = t_ff * t_ff;
      u2_full = u_ff * u_ff;
      tu_full = t_ff * u_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t2_ff   <= t2_full[qbez_pkg::SQ_W-1:0];
         u2_ff   <= u2_full[qbez_pkg::SQ_W-1:0];
         tu_ff   <= tu_full[qbez_pkg::SQ_W-1:0];
         t_s2_ff <= t_ff;
         u_s2_ff <= u_ff;
      end
   end

   // degree four from pairs of squares
   always_comb begin
      m4_full[0] = u2_ff * u2_ff;
      m4_full[1] = tu_ff * u2_ff;
      m4_full[2] = tu_ff * tu_ff;
      m4_full[3] = t2_ff * tu_ff;
      m4_full[4] = t2_ff * t2_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
            m4_ff[k] <= m4_full[k][qbez_pkg::MONO4_W-1:0];
         end
         t_s3_ff <= t_s2_ff;
         u_s3_ff <= u_s2_ff;
      end
   end

   // degree five: u^5 from u^4, the rest one more power of t
   always_comb begin
      m5_full[0] = m4_ff[0] * u_s3_ff;
      for (int k = 1; k < qbez_pkg::NUM_POINTS; k++) begin
         m5_full[k] = m4_ff[k-1] * t_s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
            m5_ff[k] <= m5_full[k][qbez_pkg::MONO5_W-1:0];
         end
         for (int k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
            m4_s4_ff[k] <= m4_ff[k];
         end
      end
   end

   assign mono4 = m4_s4_ff;
   assign mono5 = m5_ff;

endmodule

// ----- src/qbez_mac.sv -----
module qbez_mac (
   input  logic                   clock,
   input  qbez_pkg::stage_en_type en,
   input  qbez_pkg::mono4_type    mono4 [qbez_pkg::NUM_DIFFS],
   input  qbez_pkg::mono5_type    mono5 [qbez_pkg::NUM_POINTS],
   input  qbez_pkg::coef_type     coef  [qbez_pkg::NUM_POINTS],
   input  qbez_pkg::diff_type     diff  [qbez_pkg::NUM_DIFFS],
   output qbez_pkg::pos_acc_type  pos_sum,
   output qbez_pkg::slp_acc_type  slp_sum
);

   localparam int POS_PAD_W = qbez_pkg::NUM_CHUNKS * qbez_pkg::POS_CHUNK_W;
   localparam int SLP_PAD_W = qbez_pkg::NUM_CHUNKS * qbez_pkg::SLP_CHUNK_W;

   logic [POS_PAD_W-1:0] m5_pad [qbez_pkg::NUM_POINTS];
   logic [SLP_PAD_W-1:0] m4_pad [qbez_pkg::NUM_DIFFS];

   // stage five: chunk by coefficient products
   logic signed [qbez_pkg::POS_PP_W-1:0] pos_pp_in [qbez_pkg::NUM_POINTS][qbez_pkg::NUM_CHUNKS];
   logic signed [qbez_pkg::POS_PP_W-1:0] pos_pp_ff [qbez_pkg::NUM_POINTS][qbez_pkg::NUM_CHUNKS];
   logic signed [qbez_pkg::SLP_PP_W-1:0] slp_pp_in [qbez_pkg::NUM_DIFFS][qbez_pkg::NUM_CHUNKS];
   logic signed [qbez_pkg::SLP_PP_W-1:0] slp_pp_ff [qbez_pkg::NUM_DIFFS][qbez_pkg::NUM_CHUNKS];

   // stage six: one full product per term
   qbez_pkg::pos_acc_type pos_term_in [qbez_pkg::NUM_POINTS];
   qbez_pkg::pos_acc_type pos_term_ff [qbez_pkg::NUM_POINTS];
   qbez_pkg::slp_acc_type slp_term_in [qbez_pkg::NUM_DIFFS];
   qbez_pkg::slp_acc_type slp_term_ff [qbez_pkg::NUM_DIFFS];

   // stage seven: pairwise sums
   qbez_pkg::pos_acc_type pos_pair_ff [3];
   qbez_pkg::slp_acc_type slp_pair_ff [3];

   // stage eight: total plus rounding half
   qbez_pkg::pos_acc_type pos_sum_ff;
   qbez_pkg::slp_acc_type slp_sum_ff;

   // partial products, chunks are unsigned so they get a zero sign bit
   always_comb begin
      for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
         m5_pad[k] = POS_PAD_W'(mono5[k]);
         for (int j = 0; j < qbez_pkg::NUM_CHUNKS; j++) begin
            pos_pp_in[k][j] =
               $signed({1'b0, m5_pad[k][j*qbez_pkg::POS_CHUNK_W +: qbez_pkg::POS_CHUNK_W]})
               * coef[k];
         end
      end
      for (int k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
         m4_pad[k] = SLP_PAD_W'(mono4[k]);
         for (int j = 0; j < qbez_pkg::NUM_CHUNKS; j++) begin
            slp_pp_in[k][j] =
               $signed({1'b0, m4_pad[k][j*qbez_pkg::SLP_CHUNK_W +: qbez_pkg::SLP_CHUNK_W]})
               * diff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         pos_pp_ff <= pos_pp_in;
         slp_pp_ff <= slp_pp_in;
      end
   end

   // recombine the chunks at their weights
   always_comb begin
      for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
         pos_term_in[k] = '0;
         for (int j = 0; j < qbez_pkg::NUM_CHUNKS; j++) begin
            pos_term_in[k] = pos_term_in[k]
               + (qbez_pkg::pos_acc_type'(pos_pp_ff[k][j]) <<< (j * qbez_pkg::POS_CHUNK_W));
         end
      end
      for (int k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
         slp_term_in[k] = '0;
         for (int j = 0; j < qbez_pkg::NUM_CHUNKS; j++) begin
            slp_term_in[k] = slp_term_in[k]
               + (qbez_pkg::slp_acc_type'(slp_pp_ff[k][j]) <<< (j * qbez_pkg::SLP_CHUNK_W));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         pos_term_ff <= pos_term_in;
         slp_term_ff <= slp_term_in;
      end
   end

   // first level of the adder tree
   always_ff @(posedge clock) begin
      if (en[6]) begin
         pos_pair_ff[0] <= pos_term_ff[0] + pos_term_ff[1];
         pos_pair_ff[1] <= pos_term_ff[2] + pos_term_ff[3];
         pos_pair_ff[2] <= pos_term_ff[4] + pos_term_ff[5];
         slp_pair_ff[0] <= slp_term_ff[0] + slp_term_ff[1];
         slp_pair_ff[1] <= slp_term_ff[2] + slp_term_ff[3];
         slp_pair_ff[2] <= slp_term_ff[4];
      end
   end

   // final sum with half a step added for round to nearest, ties up
   always_ff @(posedge clock) begin
      if (en[7]) begin
         pos_sum_ff <= pos_pair_ff[0] + pos_pair_ff[1] + pos_pair_ff[2] + qbez_pkg::POS_HALF;
         slp_sum_ff <= slp_pair_ff[0] + slp_pair_ff[1] + slp_pair_ff[2] + qbez_pkg::SLP_HALF;
      end
   end

   assign pos_sum = pos_sum_ff;
   assign slp_sum = slp_sum_ff;

endmodule

// ----- src/quintic_bezier_evaluator.sv -----
// Quintic Bezier evaluator, one dimension, fixed point.
// Six control points (signed Q16.16) are written over the csr channel,
// index 0 to 5; other indexes are ignored. csr_ready is always high.
// Write the points only while no request is in flight.
// Each request carries a curve parameter t (unsigned Q1.16, values above one
// are taken as one). Each request gives one response: the curve value
// (signed Q16.16) and its first derivative (signed Q24.16, saturated),
// both rounded to nearest with ties towards plus infinity.
// Throughput: one request per cycle while rsp_stall is low. The work is a
// nine-register pipeline (clamp, squares, degree four, degree five, partial
// products, term recombination, two adder levels, saturating output
// register), each stage taking one request per cycle while it moves.
// rsp_valid rises once an accepted request reaches the output register.
// When rsp_stall is held the output register keeps its response and the
// stages behind it keep filling their empty slots, so requests are still
// taken until the pipeline is full; req_stall then rises.
// Reset clears all valid bits and sets every control point to zero.
module quintic_bezier_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [qbez_pkg::PARAM_W-1:0]        req_curve_param,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [qbez_pkg::POS_W-1:0]   rsp_position,
   output logic signed [qbez_pkg::SLOPE_W-1:0] rsp_slope,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qbez_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qbez_pkg::POINT_W-1:0]        csr_data
);

   localparam int LAST = qbez_pkg::NUM_STAGES - 1;
   localparam int POS_HI_W = qbez_pkg::POS_ACC_W - qbez_pkg::POS_FRAC;
   localparam int SLP_HI_W = qbez_pkg::SLP_ACC_W - qbez_pkg::SLP_FRAC;

   localparam logic signed [POS_HI_W-1:0] POS_MAX =
      POS_HI_W'({1'b0, {(qbez_pkg::POS_W-1){1'b1}}});
   localparam logic signed [POS_HI_W-1:0] POS_MIN = ~POS_MAX;
   localparam logic signed [SLP_HI_W-1:0] SLP_MAX =
      SLP_HI_W'({1'b0, {(qbez_pkg::SLOPE_W-1){1'b1}}});
   localparam logic signed [SLP_HI_W-1:0] SLP_MIN = ~SLP_MAX;

   qbez_pkg::stage_en_type en;
   qbez_pkg::stage_en_type valid_ff, valid_in;

   qbez_pkg::coef_type    coef  [qbez_pkg::NUM_POINTS];
   qbez_pkg::diff_type    diff  [qbez_pkg::NUM_DIFFS];
   qbez_pkg::mono4_type   mono4 [qbez_pkg::NUM_DIFFS];
   qbez_pkg::mono5_type   mono5 [qbez_pkg::NUM_POINTS];
   qbez_pkg::pos_acc_type pos_sum;
   qbez_pkg::slp_acc_type slp_sum;

   logic signed [POS_HI_W-1:0]          pos_hi;
   logic signed [SLP_HI_W-1:0]          slp_hi;
   logic signed [qbez_pkg::POS_W-1:0]   position_ff, position_in;
   logic signed [qbez_pkg::SLOPE_W-1:0] slope_ff, slope_in;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      en[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < qbez_pkg::NUM_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < qbez_pkg::NUM_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[LAST];

   qbez_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef),
      .diff      (diff)
   );

   qbez_basis u_basis (
      .clock       (clock),
      .en          (en),
      .curve_param (req_curve_param),
      .mono4       (mono4),
      .mono5       (mono5)
   );

   qbez_mac u_mac (
      .clock   (clock),
      .en      (en),
      .mono4   (mono4),
      .mono5   (mono5),
      .coef    (coef),
      .diff    (diff),
      .pos_sum (pos_sum),
      .slp_sum (slp_sum)
   );

   // drop the fraction bits and clamp to the output ranges
   always_comb begin
      pos_hi = pos_sum[qbez_pkg::POS_ACC_W-1:qbez_pkg::POS_FRAC];
      slp_hi = slp_sum[qbez_pkg::SLP_ACC_W-1:qbez_pkg::SLP_FRAC];
      if (pos_hi > POS_MAX) begin
         position_in = POS_MAX[qbez_pkg::POS_W-1:0];
      end else if (pos_hi < POS_MIN) begin
         position_in = POS_MIN[qbez_pkg::POS_W-1:0];
      end else begin
         position_in = pos_hi[qbez_pkg::POS_W-1:0];
      end
      if (slp_hi > SLP_MAX) begin
         slope_in = SLP_MAX[qbez_pkg::SLOPE_W-1:0];
      end else if (slp_hi < SLP_MIN) begin
         slope_in = SLP_MIN[qbez_pkg::SLOPE_W-1:0];
      end else begin
         slope_in = slp_hi[qbez_pkg::SLOPE_W-1:0];
      end
   end

   // output register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         position_ff <= position_in;
         slope_ff    <= slope_in;
      end
   end

   assign rsp_position = position_ff;
   assign rsp_slope    = slope_ff;

endmodule

// ----- bench/quintic_bezier_evaluator_tb.sv -----
module quintic_bezier_evaluator_tb;

   // register indexes the block does not decode
   localparam logic [qbez_pkg::CSR_INDEX_W-1:0] REG_SPARE_SIX   = 3'd6;
   localparam logic [qbez_pkg::CSR_INDEX_W-1:0] REG_SPARE_SEVEN = 3'd7;

   localparam qbez_pkg::param_type HALF_T    = qbez_pkg::ONE_Q16 >> 1;
   localparam qbez_pkg::param_type PARAM_TOP = '1;
   localparam qbez_pkg::param_type PARAM_BELOW_ONE =
      qbez_pkg::param_type'(qbez_pkg::ONE_Q16 - 1);
   localparam qbez_pkg::param_type PARAM_ABOVE_ONE =
      qbez_pkg::param_type'(qbez_pkg::ONE_Q16 + 1);
   localparam qbez_pkg::point_type POINT_MAX = 32'sh7fffffff;
   localparam qbez_pkg::point_type POINT_MIN = 32'sh80000000;

   localparam int BLOCKS         = 8;
   localparam int BLOCK_REQUESTS = 200;

   typedef struct {
      qbez_pkg::param_type                 param;
      logic signed [qbez_pkg::POS_W-1:0]   position;
      logic signed [qbez_pkg::SLOPE_W-1:0] slope;
   } curve_sample_type;

   // predicts curve value and derivative, checks responses in order
   class curve_scoreboard;
      qbez_pkg::point_type points [qbez_pkg::NUM_POINTS];
      curve_sample_type    predicted_samples [$];
      int unsigned         mismatches;

      function new();
         foreach (points[i]) points[i] = '0;
         mismatches = 0;
      endfunction

      function void set_point(logic [qbez_pkg::CSR_INDEX_W-1:0] index,
                              qbez_pkg::point_type value);
         if (index < qbez_pkg::NUM_POINTS) points[index] = value;
      endfunction

      function int pending();
         return predicted_samples.size();
      endfunction

      // exact bernstein sums, one rounding step each, ties towards plus infinity
      function curve_sample_type bezier_at(qbez_pkg::param_type t_in);
         logic signed [127:0] t, u, w, pk, dk, pos_acc, slp_acc, pos_q, slp_q;
         logic signed [127:0] pos_hi, pos_lo, slp_hi, slp_lo;
         curve_sample_type s;
         int k, j;
         t = 128'((t_in > qbez_pkg::ONE_Q16) ? qbez_pkg::ONE_Q16 : t_in);
         u = 128'sd65536 - t;
         pos_hi = (128'sd1 <<< (qbez_pkg::POS_W - 1)) - 128'sd1;
         pos_lo = -(128'sd1 <<< (qbez_pkg::POS_W - 1));
         slp_hi = (128'sd1 <<< (qbez_pkg::SLOPE_W - 1)) - 128'sd1;
         slp_lo = -(128'sd1 <<< (qbez_pkg::SLOPE_W - 1));
         pos_acc = '0;
         slp_acc = '0;
         // curve value, binary point at bit 80
         for (k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
            w = (k == 0 || k == 5) ? 128'sd1 : (k == 1 || k == 4) ? 128'sd5 : 128'sd10;
            for (j = 0; j < 5 - k; j++) w = w * u;
            for (j = 0; j < k; j++) w = w * t;
            pk = 128'(points[k]);
            pos_acc = pos_acc + w * pk;
         end
         // derivative from point differences, binary point at bit 64
         for (k = 0; k < qbez_pkg::NUM_DIFFS; k++) begin
            w = (k == 0 || k == 4) ? 128'sd5 : (k == 1 || k == 3) ? 128'sd20 : 128'sd30;
            for (j = 0; j < 4 - k; j++) w = w * u;
            for (j = 0; j < k; j++) w = w * t;
            pk = 128'(points[k]);
            dk = 128'(points[k + 1]);
            dk = dk - pk;
            slp_acc = slp_acc + w * dk;
         end
         pos_q = (pos_acc + (128'sd1 <<< 79)) >>> 80;
         slp_q = (slp_acc + (128'sd1 <<< 63)) >>> 64;
         if (pos_q > pos_hi) pos_q = pos_hi;
         else if (pos_q < pos_lo) pos_q = pos_lo;
         if (slp_q > slp_hi) slp_q = slp_hi;
         else if (slp_q < slp_lo) slp_q = slp_lo;
         s.param    = t_in;
         s.position = pos_q[qbez_pkg::POS_W-1:0];
         s.slope    = slp_q[qbez_pkg::SLOPE_W-1:0];
         return s;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      function void note_request(qbez_pkg::param_type t_in);
         predicted_samples.push_back(bezier_at(t_in));
      endfunction

      task check_response(logic signed [qbez_pkg::POS_W-1:0] position,
                          logic signed [qbez_pkg::SLOPE_W-1:0] slope);
         curve_sample_type want;
         if (predicted_samples.size() == 0) begin
            report($sformatf("response with nothing outstanding: position %0d slope %0d",
                             position, slope));
            return;
         end
         want = predicted_samples.pop_front();
         if (position !== want.position)
            report($sformatf("t %0d: position %0d, predicted %0d",
                             want.param, position, want.position));
         if (slope !== want.slope)
            report($sformatf("t %0d: slope %0d, predicted %0d",
                             want.param, slope, want.slope));
      endtask
   endclass

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [qbez_pkg::PARAM_W-1:0]        req_curve_param = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [qbez_pkg::POS_W-1:0]   rsp_position;
   logic signed [qbez_pkg::SLOPE_W-1:0] rsp_slope;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [qbez_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [qbez_pkg::POINT_W-1:0]        csr_data = '0;

   int unsigned         send_idle_pct  = 0;
   int unsigned         recv_stall_pct = 0;
   qbez_pkg::point_type curve_plan [qbez_pkg::NUM_POINTS];
   curve_scoreboard     sb = new();

   quintic_bezier_evaluator uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_curve_param (req_curve_param),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_slope       (rsp_slope),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on run length
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // note accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_curve_param);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_position, rsp_slope);
      end
   end

   task automatic send_request(input qbez_pkg::param_type t);
      req_valid       <= 1'b1;
      req_curve_param <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // let the last request be noted, then wait for every response and for the pipeline to empty
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (qbez_pkg::NUM_STAGES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [qbez_pkg::CSR_INDEX_W-1:0] index,
                            input qbez_pkg::point_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_point(index, value);
   endtask

   // write a spare index, then load the planned points while the pipeline is empty
   task automatic reprogram_points();
      req_valid <= 1'b0;
      wait_drained();
      csr_write($urandom_range(1) ? REG_SPARE_SEVEN : REG_SPARE_SIX,
                qbez_pkg::point_type'($urandom()));
      for (int i = 0; i < qbez_pkg::NUM_POINTS; i++)
         csr_write(qbez_pkg::csr_reg_type'(i), curve_plan[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic use_points(input qbez_pkg::point_type p0, p1, p2, p3, p4, p5);
      curve_plan = '{p0, p1, p2, p3, p4, p5};
      reprogram_points();
   endtask

   function automatic qbez_pkg::point_type random_point();
      case ($urandom_range(3))
         0: return qbez_pkg::point_type'($urandom());
         1: return qbez_pkg::point_type'(int'($urandom_range(4096)) - 2048);
         2: begin
            case ($urandom_range(3))
               0: return POINT_MAX;
               1: return POINT_MIN;
               2: return '0;
               default: return -32'sd1;
            endcase
         end
         default: return qbez_pkg::point_type'(int'($urandom_range(33554432)) - 16777216);
      endcase
   endfunction

   function automatic qbez_pkg::param_type random_param();
      case ($urandom_range(15))
         0: begin
            case ($urandom_range(3))
               0: return '0;
               1: return qbez_pkg::param_type'(1);
               2: return PARAM_BELOW_ONE;
               default: return qbez_pkg::ONE_Q16;
            endcase
         end
         1: return qbez_pkg::param_type'($urandom_range(PARAM_TOP, PARAM_ABOVE_ONE));
         default: return qbez_pkg::param_type'($urandom_range(qbez_pkg::ONE_Q16));
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // points straight out of reset
      send_request('0);
      send_request(qbez_pkg::ONE_Q16);

      // all points at the top of the range
      use_points(POINT_MAX, POINT_MAX, POINT_MAX, POINT_MAX, POINT_MAX, POINT_MAX);
      send_request('0);
      send_request(HALF_T);
      send_request(qbez_pkg::ONE_Q16);

      // alternating extremes for the steepest derivative, t beyond one
      use_points(POINT_MIN, POINT_MAX, POINT_MIN, POINT_MAX, POINT_MIN, POINT_MAX);
      send_request('0);
      send_request(qbez_pkg::param_type'(1));
      send_request(HALF_T);
      send_request(PARAM_BELOW_ONE);
      send_request(qbez_pkg::ONE_Q16);
      send_request(PARAM_ABOVE_ONE);
      send_request(PARAM_TOP);

      use_points(POINT_MIN, POINT_MIN, POINT_MIN, POINT_MIN, POINT_MIN, POINT_MIN);
      send_request('0);
      send_request(PARAM_TOP);

      // value lands exactly half a step off, either sign
      use_points(32'sd16, '0, '0, '0, '0, '0);
      send_request(HALF_T);
      use_points(-32'sd16, '0, '0, '0, '0, '0);
      send_request(HALF_T);

      // derivative lands exactly half a step off, either sign
      use_points('0, 32'sd8, 32'sd8, 32'sd8, 32'sd8, 32'sd8);
      send_request(HALF_T);
      use_points('0, -32'sd8, -32'sd8, -32'sd8, -32'sd8, -32'sd8);
      send_request(HALF_T);

      // random blocks, each with fresh points; the idling pattern changes by group of blocks
      for (int blk = 0; blk < BLOCKS; blk++) begin
         if (blk < 3) begin
            send_idle_pct  = 12;
            recv_stall_pct = 80;
         end else if (blk < 6) begin
            send_idle_pct  = 80;
            recv_stall_pct = 12;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         foreach (curve_plan[i]) curve_plan[i] = random_point();
         reprogram_points();
         for (int n = 0; n < BLOCK_REQUESTS; n++) begin
            send_request(random_param());
            if (n == BLOCK_REQUESTS / 2) begin
               // sender holds off until the pipeline has emptied
               req_valid <= 1'b0;
               wait_drained();
            end else begin
               sender_gap();
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
src/qbez_pkg.sv
src/qbez_csr.sv
src/qbez_basis.sv
src/qbez_mac.sv
src/quintic_bezier_evaluator.sv
bench/quintic_bezier_evaluator_tb.sv
